// ===== sv/dbspm_pkg.sv =====
package dbspm_pkg;

  localparam int unsigned DefaultSlots = 2;
  localparam int unsigned MaxSlots     = 8;
  localparam int unsigned SlotW        = 3;
  localparam int unsigned CoordW       = 9;
  localparam int unsigned EdgeW        = 10;
  localparam int unsigned ColorW       = 16;

  localparam logic [2:0] OpAlloc     = 3'd0;
  localparam logic [2:0] OpSend      = 3'd1;
  localparam logic [2:0] OpVideoDone = 3'd2;
  localparam logic [2:0] OpClearDone = 3'd3;
  localparam logic [2:0] OpSetBg     = 3'd4;
  localparam logic [2:0] OpInit      = 3'd5;

  localparam logic [2:0] SsCleared   = 3'd0;
  localparam logic [2:0] SsDrawing   = 3'd1;
  localparam logic [2:0] SsSendWait  = 3'd2;
  localparam logic [2:0] SsSending   = 3'd3;
  localparam logic [2:0] SsClearWait = 3'd4;
  localparam logic [2:0] SsClearing  = 3'd5;

  localparam logic [1:0] KindGrant = 2'd0;
  localparam logic [1:0] KindVideo = 2'd1;
  localparam logic [1:0] KindClear = 2'd2;

  typedef struct packed {
    logic [2:0]        operation;
    logic [SlotW-1:0]  slot;
    logic [CoordW-1:0] x_origin;
    logic [CoordW-1:0] y_origin;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] height;
    logic              transfer_complete;
    logic [ColorW-1:0] color;
    logic              immediate;
  } req_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SlotW-1:0]  result_slot;
    logic              found;
    logic [CoordW-1:0] x_first;
    logic [EdgeW-1:0]  x_last;
    logic [CoordW-1:0] y_first;
    logic [EdgeW-1:0]  y_last;
    logic [ColorW-1:0] fill_color;
    logic              last;
  } rsp_item_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             flush;
    logic [SlotW-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic stop;
    logic pend_vld;
    logic out_free;
  } status_t;

endpackage

// ===== sv/dbspm_req_if.sv =====
interface dbspm_req_if import dbspm_pkg::*; ();
  logic      valid;
  logic      ready;
  req_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== sv/dbspm_rsp_if.sv =====
interface dbspm_rsp_if import dbspm_pkg::*; ();
  logic      valid;
  logic      ready;
  rsp_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== sv/dbspm_ctrl.sv =====
module dbspm_ctrl import dbspm_pkg::*; #(
  parameter int unsigned SLOTS = DefaultSlots
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          step_ok;

  assign in_ready_o = (state_q == StIdle);
  assign step_ok    = !sts_i.emit || !sts_i.pend_vld || sts_i.out_free;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    cmd_o.idx   = SlotW'(idx_q);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (step_ok) begin
          cmd_o.step = 1'b1;
          if (sts_i.stop || idx_q == LastIdx) begin
            state_d = StFlush;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      StFlush: begin
        if (!sts_i.pend_vld) begin
          state_d = StIdle;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== sv/dbspm_dpath.sv =====
module dbspm_dpath import dbspm_pkg::*; #(
  parameter int unsigned SLOTS = DefaultSlots
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  dbspm_req_if.sink          req_i,
  dbspm_rsp_if.source        rsp_o,
  input  cmd_t               cmd_i,
  output status_t            sts_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [2:0]        status_q [SLOTS];
  logic [CoordW-1:0] win_x_q  [SLOTS];
  logic [CoordW-1:0] win_y_q  [SLOTS];
  logic [CoordW-1:0] win_w_q  [SLOTS];
  logic [CoordW-1:0] win_h_q  [SLOTS];
  logic              vbusy_q, cbusy_q;
  logic [ColorW-1:0] bg_q;
  req_item_t         item_q;
  rsp_item_t         pend_q, out_q, out_d;
  logic              pend_vld_q, out_vld_q;

  logic [IW-1:0]     sel;
  logic [2:0]        cur, nst;
  logic              send_ok, wr_st, wr_win, vset, cset, emit, stop;
  logic              do_video, do_clear;
  rsp_item_t         res;
  logic              out_free, push_step, push_out;

  assign send_ok = ({1'b0, item_q.slot} < (SlotW + 1)'(SLOTS));
  assign sel     = (item_q.operation == OpSend) ? item_q.slot[IW-1:0] : cmd_i.idx[IW-1:0];
  assign cur     = status_q[sel];

  always_comb begin
    nst      = cur;
    wr_st    = 1'b0;
    wr_win   = 1'b0;
    vset     = 1'b0;
    cset     = 1'b0;
    emit     = 1'b0;
    stop     = 1'b0;
    do_video = 1'b0;
    do_clear = 1'b0;
    res      = '0;
    case (item_q.operation)
      OpAlloc: begin
        if (cur == SsCleared) begin
          nst             = SsDrawing;
          wr_st           = 1'b1;
          wr_win          = 1'b1;
          emit            = 1'b1;
          stop            = 1'b1;
          res.kind        = KindGrant;
          res.result_slot = SlotW'(sel);
          res.found       = 1'b1;
        end else if (cmd_i.idx[IW-1:0] == IW'(SLOTS - 1)) begin
          emit     = 1'b1;
          res.kind = KindGrant;
        end
      end
      OpSend: begin
        stop = 1'b1;
        if (send_ok) begin
          if (vbusy_q) begin
            nst   = SsSendWait;
            wr_st = 1'b1;
          end else begin
            do_video = 1'b1;
          end
        end
      end
      OpVideoDone: begin
        if (item_q.transfer_complete) begin
          if (cur == SsSending) begin
            do_clear = 1'b1;
          end else if (cur == SsSendWait && !vbusy_q) begin
            do_video = 1'b1;
          end
        end
      end
      OpClearDone: begin
        if (cur == SsClearing) begin
          nst   = SsCleared;
          wr_st = 1'b1;
        end else if (cur == SsClearWait && !cbusy_q) begin
          nst             = SsClearing;
          wr_st           = 1'b1;
          cset            = 1'b1;
          emit            = 1'b1;
          res.kind        = KindClear;
          res.result_slot = SlotW'(sel);
          res.fill_color  = bg_q;
        end
      end
      OpSetBg: begin
        if (item_q.immediate && cur == SsCleared) begin
          do_clear = 1'b1;
        end
      end
      OpInit: begin
        do_clear = 1'b1;
      end
      default: begin
        stop = 1'b1;
      end
    endcase

    if (do_video) begin
      nst             = SsSending;
      wr_st           = 1'b1;
      vset            = 1'b1;
      emit            = 1'b1;
      res.kind        = KindVideo;
      res.result_slot = SlotW'(sel);
      res.x_first     = win_x_q[sel];
      res.x_last      = EdgeW'({1'b0, win_x_q[sel]} + {1'b0, win_w_q[sel]} - 10'd1);
      res.y_first     = win_y_q[sel];
      res.y_last      = EdgeW'({1'b0, win_y_q[sel]} + {1'b0, win_h_q[sel]} - 10'd1);
    end
    if (do_clear) begin
      wr_st = 1'b1;
      if (cbusy_q) begin
        nst = SsClearWait;
      end else begin
        nst             = SsClearing;
        cset            = 1'b1;
        emit            = 1'b1;
        res.kind        = KindClear;
        res.result_slot = SlotW'(sel);
        res.fill_color  = bg_q;
      end
    end
  end

  always_comb begin
    out_d      = pend_q;
    out_d.last = cmd_i.flush;
  end

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign push_step = cmd_i.step && emit;
  assign push_out  = (push_step && pend_vld_q) || cmd_i.flush;

  assign sts_o.emit     = emit;
  assign sts_o.stop     = stop;
  assign sts_o.pend_vld = pend_vld_q;
  assign sts_o.out_free = out_free;

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.item  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        status_q[i] <= SsCleared;
      end
      vbusy_q <= 1'b0;
      cbusy_q <= 1'b0;
      bg_q    <= '0;
    end else if (cmd_i.load) begin
      if (req_i.item.operation == OpVideoDone && req_i.item.transfer_complete) begin
        vbusy_q <= 1'b0;
      end
      if (req_i.item.operation == OpClearDone) begin
        cbusy_q <= 1'b0;
      end
      if (req_i.item.operation == OpSetBg) begin
        bg_q <= req_i.item.color;
      end
    end else if (cmd_i.step) begin
      if (wr_st) begin
        status_q[sel] <= nst;
      end
      if (vset) begin
        vbusy_q <= 1'b1;
      end
      if (cset) begin
        cbusy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= req_i.item;
    end
    if (cmd_i.step && wr_win) begin
      win_x_q[sel] <= item_q.x_origin;
      win_y_q[sel] <= item_q.y_origin;
      win_w_q[sel] <= item_q.width;
      win_h_q[sel] <= item_q.height;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (push_step) begin
        pend_vld_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_vld_q <= 1'b0;
      end
      if (push_out) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_out) begin
      out_q <= out_d;
    end
    if (push_step) begin
      pend_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_flush_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |-> pend_vld_q)
    else $error("Flush issued with no pending result.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_step && pend_vld_q) |-> out_free)
    else $error("Pending result pushed into an occupied output register.");

  a_flush_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> (out_vld_q && out_q.last && !pend_vld_q))
    else $error("Flush did not present the final beat of the item.");

  a_nonlast_has_successor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.last) |-> pend_vld_q)
    else $error("Non-final beat presented with no later result held.");

  a_load_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !pend_vld_q)
    else $error("New item loaded while a result of the previous one is held.");
`endif

endmodule

// ===== sv/double_buffer_slice_pool_manager.sv =====
// An accepted item is loaded, then the controller scans the slots in order until a slot stops
// the scan or the last slot is reached, and then flushes any held result as the final beat.
// A new item is accepted only once the controller is idle again; stalls on the result
// channel hold the scan and the flush while the output register stays full.
// Reset is asynchronous and active low: every slot returns to cleared, both engines to idle,
// the background colour to black, and no result is held; the slot windows are not cleared.
module double_buffer_slice_pool_manager import dbspm_pkg::*; #(
  parameter int unsigned SLOTS = DefaultSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbspm_req_if.sink   req_i,
  dbspm_rsp_if.source rsp_o
);

  cmd_t    cmd;
  status_t sts;
  logic    in_ready;

  assign req_i.ready = in_ready;

  dbspm_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbspm_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
